// ===== rtl/core/lsbse_pkg.sv =====
// shared types and constants for the lsb stego embedder
package lsbse_pkg;

   // phase codes, in stream order
   localparam logic [2:0] PH_HEADER = 3'd0;
   localparam logic [2:0] PH_MAGIC  = 3'd1;
   localparam logic [2:0] PH_EXTLEN = 3'd2;
   localparam logic [2:0] PH_EXT    = 3'd3;
   localparam logic [2:0] PH_SIZE   = 3'd4;
   localparam logic [2:0] PH_DATA   = 3'd5;
   localparam logic [2:0] PH_COPY   = 3'd6;

   // register indexes on the csr port
   localparam logic [2:0] REG_HEADER_LENGTH    = 3'd0;
   localparam logic [2:0] REG_MAGIC_BYTES      = 3'd1;
   localparam logic [2:0] REG_MAGIC_LENGTH     = 3'd2;
   localparam logic [2:0] REG_EXTENSION_BYTES  = 3'd3;
   localparam logic [2:0] REG_EXTENSION_LENGTH = 3'd4;
   localparam logic [2:0] REG_SECRET_SIZE      = 3'd5;

   localparam int unsigned POS_W = 35;

   // word-sized fields (extension length, secret size)
   localparam logic [POS_W-1:0] WORD_BITS = POS_W'(32);
   localparam logic [3:0] MAX_CHARS = 4'd8;

   typedef struct packed {
      logic [9:0]  header_length;
      logic [63:0] magic_bytes;
      logic [3:0]  magic_length;
      logic [63:0] extension_bytes;
      logic [3:0]  extension_length;
      logic [31:0] secret_size;
   } cfg_type;

   // outcome of one request, computed by the selector
   typedef struct packed {
      logic [2:0]       phase;
      logic [POS_W-1:0] pos_next;
      logic             embed;
      logic             bit_val;
      logic             taken;
      logic [7:0]       shift_next;
   } step_type;

endpackage

// ===== rtl/core/lsbse_sel.sv =====
// phase resolution and embed bit selection for one request
module lsbse_sel import lsbse_pkg::*; (
   input  cfg_type          cfg,
   input  logic [2:0]       phase_ff,
   input  logic [POS_W-1:0] pos_ff,
   input  logic [7:0]       shift_ff,
   input  logic [7:0]       payload_byte,
   output step_type         step
);

   logic [3:0]       magic_sat;
   logic [3:0]       ext_sat;
   logic [POS_W-1:0] cur_len;
   logic [2:0]       after_phase;
   logic [2:0]       eff_phase;
   logic [POS_W-1:0] eff_pos;
   logic [31:0]      extlen_word;

   // saturate character counts at eight
   assign magic_sat   = (cfg.magic_length > MAX_CHARS) ? MAX_CHARS : cfg.magic_length;
   assign ext_sat     = (cfg.extension_length > MAX_CHARS) ? MAX_CHARS : cfg.extension_length;
   assign extlen_word = {28'd0, ext_sat};

   // length of the phase held in state
   always_comb begin
      unique case (phase_ff)
         PH_HEADER: cur_len = {25'd0, cfg.header_length};
         PH_MAGIC:  cur_len = {28'd0, magic_sat, 3'b000};
         PH_EXTLEN: cur_len = WORD_BITS;
         PH_EXT:    cur_len = {28'd0, ext_sat, 3'b000};
         PH_SIZE:   cur_len = WORD_BITS;
         PH_DATA:   cur_len = {cfg.secret_size, 3'b000};
         default:   cur_len = '0;
      endcase
   end

   // next non-empty phase after the current one
   always_comb begin
      unique case (phase_ff)
         PH_HEADER: after_phase = (magic_sat != 4'd0) ? PH_MAGIC : PH_EXTLEN;
         PH_MAGIC:  after_phase = PH_EXTLEN;
         PH_EXTLEN: after_phase = (ext_sat != 4'd0) ? PH_EXT : PH_SIZE;
         PH_EXT:    after_phase = PH_SIZE;
         PH_SIZE:   after_phase = (cfg.secret_size != 32'd0) ? PH_DATA : PH_COPY;
         default:   after_phase = PH_COPY;
      endcase
   end

   // stay, or move on with the position restarted
   always_comb begin
      priority if (phase_ff >= PH_COPY) begin
         eff_phase = PH_COPY;
         eff_pos   = '0;
      end else if (pos_ff < cur_len) begin
         eff_phase = phase_ff;
         eff_pos   = pos_ff;
      end else begin
         eff_phase = after_phase;
         eff_pos   = '0;
      end
   end

   // bit to embed, payload load and shift
   always_comb begin
      step.phase      = eff_phase;
      step.pos_next   = (eff_phase == PH_COPY) ? '0 : eff_pos + POS_W'(1);
      step.embed      = 1'b1;
      step.bit_val    = 1'b0;
      step.taken      = 1'b0;
      step.shift_next = shift_ff;
      unique case (eff_phase)
         PH_MAGIC:  step.bit_val = cfg.magic_bytes[6'd63 - eff_pos[5:0]];
         PH_EXTLEN: step.bit_val = extlen_word[5'd31 - eff_pos[4:0]];
         PH_EXT:    step.bit_val = cfg.extension_bytes[6'd63 - eff_pos[5:0]];
         PH_SIZE:   step.bit_val = cfg.secret_size[5'd31 - eff_pos[4:0]];
         PH_DATA: begin
            if (eff_pos[2:0] == 3'd0) begin
               step.taken      = 1'b1;
               step.bit_val    = payload_byte[7];
               step.shift_next = {payload_byte[6:0], 1'b0};
            end else begin
               step.bit_val    = shift_ff[7];
               step.shift_next = {shift_ff[6:0], 1'b0};
            end
         end
         default:   step.embed = 1'b0;
      endcase
   end

endmodule

// ===== rtl/core/lsb_stego_embedder.sv =====
// top level of the lsb stego embedder: state, csr registers and result register
//
// channel  dir  signals                      content
// req      in   req_tvalid/tready/tdata      image_byte, payload_byte
// rsp      out  rsp_tvalid/tready/tdata/user stego_byte; phase, payload_taken
// csr      in   csr_we/csr_index/csr_wdata   register writes, no read-back
//
// one request per cycle while the result is not stalled; each result appears in the cycle after its request
// the phase decision and bit select sit between the state and the result register
// reset clears phase, position, shift state and the result valid
// a stalled result holds in its register and blocks only the next request
module lsb_stego_embedder import lsbse_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] image_byte, [15:8] payload_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] stego_byte
   output logic [3:0]  rsp_tuser,   // [2:0] phase, [3] payload_taken
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   cfg_type          cfg_ff;
   logic [2:0]       phase_ff;
   logic [POS_W-1:0] pos_ff;
   logic [7:0]       shift_ff;
   logic             rsp_valid_ff;
   logic [7:0]       rsp_byte_ff;
   logic [3:0]       rsp_user_ff;
   step_type         step;
   logic             req_fire;
   logic [7:0]       rsp_byte_in;

   // csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{header_length: 10'd54, default: '0};
      end else if (csr_we) begin
         unique case (csr_index)
            REG_HEADER_LENGTH:    cfg_ff.header_length    <= csr_wdata[9:0];
            REG_MAGIC_BYTES:      cfg_ff.magic_bytes      <= csr_wdata;
            REG_MAGIC_LENGTH:     cfg_ff.magic_length     <= csr_wdata[3:0];
            REG_EXTENSION_BYTES:  cfg_ff.extension_bytes  <= csr_wdata;
            REG_EXTENSION_LENGTH: cfg_ff.extension_length <= csr_wdata[3:0];
            REG_SECRET_SIZE:      cfg_ff.secret_size      <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   lsbse_sel u_sel (
      .cfg          (cfg_ff),
      .phase_ff     (phase_ff),
      .pos_ff       (pos_ff),
      .shift_ff     (shift_ff),
      .payload_byte (req_tdata[15:8]),
      .step         (step)
   );

   // handshake
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   // output byte with lsb replaced while embedding
   assign rsp_byte_in = step.embed ? {req_tdata[7:1], step.bit_val} : req_tdata[7:0];

   // stream state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         pos_ff   <= '0;
         shift_ff <= '0;
      end else if (req_fire) begin
         phase_ff <= step.phase;
         pos_ff   <= step.pos_next;
         shift_ff <= step.shift_next;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_byte_ff <= rsp_byte_in;
         rsp_user_ff <= {step.taken, step.phase};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tuser  = rsp_user_ff;

   // phase only moves forward between resets
   a_phase_forward: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> phase_ff >= $past(phase_ff))
      else $error("phase moved backward");

   // the copy phase keeps the position at zero
   a_copy_pos: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_COPY |-> pos_ff == '0)
      else $error("position count moved in copy phase");

   // payload is only consumed in the data phase
   a_taken_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_user_ff[3] |-> rsp_user_ff[2:0] == PH_DATA)
      else $error("payload taken outside data phase");

   // no request is taken over a stalled result
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |-> !req_tready)
      else $error("request accepted while result stalled");

endmodule
